@@ hw/rtl/x86_modrm_destination_writeback_defines.svh @@
// Assertion macros for the destination write-back block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef X86_MODRM_DESTINATION_WRITEBACK_DEFINES_SVH
`define X86_MODRM_DESTINATION_WRITEBACK_DEFINES_SVH

`define X86MDW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("x86mdw: same-cycle check failed");

`define X86MDW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("x86mdw: next-cycle check failed");

`endif

@@ hw/rtl/x86mdw_pkg.sv @@
// Package for the destination write-back block: codes, indexes, types.
// No dependencies.
`default_nettype none
package x86mdw_pkg;

  typedef enum logic [2:0] {
    FUNC_MODRM  = 3'd0,
    FUNC_WR_GEN = 3'd1,
    FUNC_WR_SEG = 3'd2,
    FUNC_RD_GEN = 3'd3,
    FUNC_RD_SEG = 3'd4
  } func_e;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] RM_DIRECT  = 3'd6;

  localparam logic [2:0] IDX_BX = 3'd3;
  localparam logic [2:0] IDX_BP = 3'd5;
  localparam logic [2:0] IDX_SI = 3'd6;
  localparam logic [2:0] IDX_DI = 3'd7;

  localparam logic [1:0] SEG_CS = 2'd1;
  localparam logic [1:0] SEG_SS = 2'd2;
  localparam logic [1:0] SEG_DS = 2'd3;

  localparam int unsigned NUM_GEN = 8;
  localparam int unsigned NUM_SEG = 4;

  typedef struct packed {
    logic        gen_we;
    logic [2:0]  gen_idx;
    logic        gen_lo_en;
    logic        gen_hi_en;
    logic        seg_we;
    logic [1:0]  seg_idx;
    logic [15:0] data;
  } wr_t;

  typedef struct packed {
    logic [15:0] bx;
    logic [15:0] bp;
    logic [15:0] si;
    logic [15:0] di;
    logic [15:0] ds;
  } base_t;

endpackage
`default_nettype wire

@@ hw/rtl/x86mdw_regs.sv @@
// General and segment register file with byte-lane write enables on the general registers.
// Depends on x86mdw_pkg.
`default_nettype none
module x86mdw_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire x86mdw_pkg::wr_t  wr_i,
  input  wire logic [2:0]       gen_rd_idx_i,
  input  wire logic [1:0]       seg_rd_idx_i,
  output logic [15:0]           gen_rd_o,
  output logic [15:0]           seg_rd_o,
  output x86mdw_pkg::base_t     base_o
);

  logic [15:0] gen_q [x86mdw_pkg::NUM_GEN];
  logic [15:0] seg_q [x86mdw_pkg::NUM_SEG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < x86mdw_pkg::NUM_GEN; i++) gen_q[i] <= '0;
      for (int i = 0; i < x86mdw_pkg::NUM_SEG; i++) seg_q[i] <= '0;
    end else begin
      for (int i = 0; i < x86mdw_pkg::NUM_GEN; i++) begin
        if (wr_i.gen_we && (wr_i.gen_idx == 3'(i))) begin
          if (wr_i.gen_lo_en) gen_q[i][7:0]  <= wr_i.data[7:0];
          if (wr_i.gen_hi_en) gen_q[i][15:8] <= wr_i.data[15:8];
        end
      end
      for (int i = 0; i < x86mdw_pkg::NUM_SEG; i++) begin
        if (wr_i.seg_we && (wr_i.seg_idx == 2'(i))) seg_q[i] <= wr_i.data;
      end
    end
  end

  assign gen_rd_o  = gen_q[gen_rd_idx_i];
  assign seg_rd_o  = seg_q[seg_rd_idx_i];
  assign base_o.bx = gen_q[x86mdw_pkg::IDX_BX];
  assign base_o.bp = gen_q[x86mdw_pkg::IDX_BP];
  assign base_o.si = gen_q[x86mdw_pkg::IDX_SI];
  assign base_o.di = gen_q[x86mdw_pkg::IDX_DI];
  assign base_o.ds = seg_q[x86mdw_pkg::SEG_DS];

endmodule
`default_nettype wire

@@ hw/rtl/x86mdw_agen.sv @@
// Effective and physical address generation for mod/rm memory operands.
// Depends on x86mdw_pkg.
`default_nettype none
module x86mdw_agen (
  input  wire logic [1:0]        mod_bits_i,
  input  wire logic [2:0]        rm_i,
  input  wire logic [15:0]       displacement_i,
  input  wire x86mdw_pkg::base_t base_i,
  output logic [19:0]            phys_o
);

  logic [15:0] base_a;
  logic [15:0] base_b;
  logic [15:0] disp_eff;
  logic [15:0] offset;

  always_comb begin
    base_b = '0;
    case (rm_i)
      3'd0: begin
        base_a = base_i.bx;
        base_b = base_i.si;
      end
      3'd1: begin
        base_a = base_i.bx;
        base_b = base_i.di;
      end
      3'd2: begin
        base_a = base_i.bp;
        base_b = base_i.si;
      end
      3'd3: begin
        base_a = base_i.bp;
        base_b = base_i.di;
      end
      3'd4: base_a = base_i.si;
      3'd5: base_a = base_i.di;
      3'd6: base_a = (mod_bits_i == x86mdw_pkg::MOD_NODISP) ? 16'd0 : base_i.bp;
      default: base_a = base_i.bx;
    endcase
    disp_eff = ((mod_bits_i != x86mdw_pkg::MOD_NODISP) || (rm_i == x86mdw_pkg::RM_DIRECT))
               ? displacement_i : 16'd0;
  end

  assign offset = base_a + base_b + disp_eff;
  assign phys_o = {base_i.ds, 4'd0} + {4'd0, offset};

endmodule
`default_nettype wire

@@ hw/rtl/x86_modrm_destination_writeback.sv @@
// Destination write-back stage: input register, decode and result register.
// Order: the input register takes the command; done_o and results then load together.
// Throughput: one command per cycle; busy_o is never raised, the receiver cannot stall.
// Reset: asynchronous, active low; clears all general and segment registers
// and the valid flags of both register stages.
// Depends on x86mdw_pkg, x86mdw_regs, x86mdw_agen and the defines header.
`default_nettype none
`include "x86_modrm_destination_writeback_defines.svh"
module x86_modrm_destination_writeback (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [1:0]  mod_bits_i,
  input  wire logic [2:0]  reg_index_i,
  input  wire logic        byte_mode_i,
  input  wire logic        dst_enabled_i,
  input  wire logic [15:0] write_value_i,
  input  wire logic        word_write_i,
  input  wire logic [15:0] displacement_i,
  output logic             done_o,
  output logic             mem_write_o,
  output logic [19:0]      mem_address_o,
  output logic [15:0]      mem_data_o,
  output logic             mem_word_o,
  output logic             fault_o,
  output logic             ie_clear_o,
  output logic [15:0]      read_data_o
);

  logic        in_valid_q;
  logic [2:0]  func_q;
  logic [1:0]  mod_q;
  logic [2:0]  idx_q;
  logic        byte_q;
  logic        en_q;
  logic [15:0] value_q;
  logic        word_q;
  logic [15:0] disp_q;

  x86mdw_pkg::wr_t   wr;
  x86mdw_pkg::base_t base;
  logic [15:0]       gen_rd;
  logic [15:0]       seg_rd;
  logic [19:0]       phys;
  logic              gen_wr;
  logic              seg_ok;

  logic        done_q;
  logic        mem_write_d, mem_write_q;
  logic [19:0] mem_address_d, mem_address_q;
  logic [15:0] mem_data_d, mem_data_q;
  logic        mem_word_d, mem_word_q;
  logic        fault_d, fault_q;
  logic        ie_clear_d, ie_clear_q;
  logic [15:0] read_data_d, read_data_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      func_q  <= func_i;
      mod_q   <= mod_bits_i;
      idx_q   <= reg_index_i;
      byte_q  <= byte_mode_i;
      en_q    <= dst_enabled_i;
      value_q <= write_value_i;
      word_q  <= word_write_i;
      disp_q  <= displacement_i;
    end
  end

  x86mdw_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .gen_rd_idx_i (idx_q),
    .seg_rd_idx_i (idx_q[1:0]),
    .gen_rd_o     (gen_rd),
    .seg_rd_o     (seg_rd),
    .base_o       (base)
  );

  x86mdw_agen u_agen (
    .mod_bits_i     (mod_q),
    .rm_i           (idx_q),
    .displacement_i (disp_q),
    .base_i         (base),
    .phys_o         (phys)
  );

  always_comb begin
    mem_write_d   = 1'b0;
    mem_address_d = '0;
    mem_data_d    = '0;
    mem_word_d    = 1'b0;
    fault_d       = 1'b0;
    ie_clear_d    = 1'b0;
    read_data_d   = '0;
    gen_wr        = 1'b0;
    seg_ok        = !byte_q && !idx_q[2] && (idx_q[1:0] != x86mdw_pkg::SEG_CS);
    wr.seg_we     = 1'b0;
    case (func_q)
      x86mdw_pkg::FUNC_MODRM: begin
        if (en_q) begin
          if (mod_q == x86mdw_pkg::MOD_REG) begin
            gen_wr = 1'b1;
          end else begin
            mem_write_d   = 1'b1;
            mem_address_d = phys;
            mem_data_d    = word_q ? value_q : {8'd0, value_q[7:0]};
            mem_word_d    = word_q;
          end
        end
      end
      x86mdw_pkg::FUNC_WR_GEN: gen_wr = en_q;
      x86mdw_pkg::FUNC_WR_SEG: begin
        if (en_q) begin
          fault_d    = !seg_ok;
          wr.seg_we  = seg_ok;
          ie_clear_d = seg_ok && (idx_q[1:0] == x86mdw_pkg::SEG_SS);
        end
      end
      x86mdw_pkg::FUNC_RD_GEN: read_data_d = gen_rd;
      x86mdw_pkg::FUNC_RD_SEG: read_data_d = seg_rd;
      default: ;
    endcase
    // gate every write with the stage valid
    wr.gen_we    = in_valid_q && gen_wr;
    wr.seg_we    = in_valid_q && wr.seg_we;
    wr.seg_idx   = idx_q[1:0];
    wr.gen_idx   = byte_q ? {1'b0, idx_q[1:0]} : idx_q;
    wr.gen_lo_en = !byte_q || !idx_q[2];
    wr.gen_hi_en = !byte_q || idx_q[2];
    wr.data      = byte_q ? {value_q[7:0], value_q[7:0]} : value_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      mem_write_q   <= mem_write_d;
      mem_address_q <= mem_address_d;
      mem_data_q    <= mem_data_d;
      mem_word_q    <= mem_word_d;
      fault_q       <= fault_d;
      ie_clear_q    <= ie_clear_d;
      read_data_q   <= read_data_d;
    end
  end

  assign done_o        = done_q;
  assign mem_write_o   = mem_write_q;
  assign mem_address_o = mem_address_q;
  assign mem_data_o    = mem_data_q;
  assign mem_word_o    = mem_word_q;
  assign fault_o       = fault_q;
  assign ie_clear_o    = ie_clear_q;
  assign read_data_o   = read_data_q;

  `X86MDW_ASSERT_NEXT(a_stage_to_done, in_valid_q, done_o)
  `X86MDW_ASSERT_SAME(a_one_effect, done_o, !(mem_write_o && (fault_o || ie_clear_o)))
  `X86MDW_ASSERT_SAME(a_fault_no_write, in_valid_q && fault_d, !wr.seg_we && !wr.gen_we)
  `X86MDW_ASSERT_SAME(a_single_target, wr.gen_we, !wr.seg_we && !mem_write_d)

endmodule
`default_nettype wire
